FILE: src/ipwd_pkg.sv
// ipwd_pkg: shared types, register indexes, reset values and the width window match.
// No dependencies; imported by every module of the IR pulse width decoder.
`default_nettype none
package ipwd_pkg;

   localparam int unsigned TimeW    = 16;
   localparam int unsigned TolW     = 15;
   localparam int unsigned CodeW    = 8;
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned ReqDataW = 24;
   localparam int unsigned RspDataW = 16;

   localparam logic [TimeW-1:0] PeriodReset = 16'd10000;
   localparam logic [TimeW-1:0] ZeroReset   = 16'd300;
   localparam logic [TimeW-1:0] OneReset    = 16'd600;
   localparam logic [TimeW-1:0] LeaderReset = 16'd900;
   localparam logic [TimeW-1:0] EndReset    = 16'd1200;
   localparam logic [TolW-1:0]  TolReset    = 15'd50;

   localparam logic [CodeW-1:0] AcceptMax = 8'd2;
   localparam logic [1:0]       CountMax  = 2'd3;
   localparam logic [1:0]       CountTrig = 2'd2;

   typedef enum logic [CsrAddrW-1:0] {
      REG_TIMER_PERIOD = 3'd0,
      REG_ZERO_WIDTH   = 3'd1,
      REG_ONE_WIDTH    = 3'd2,
      REG_LEADER_WIDTH = 3'd3,
      REG_END_WIDTH    = 3'd4,
      REG_TOLERANCE    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [TimeW-1:0] timer_period;
      logic [TimeW-1:0] zero_width;
      logic [TimeW-1:0] one_width;
      logic [TimeW-1:0] leader_width;
      logic [TimeW-1:0] end_width;
      logic [TolW-1:0]  tolerance;
   } cfg_type;

   typedef struct packed {
      logic zero_hit;
      logic one_hit;
      logic leader_hit;
      logic end_hit;
   } class_type;

   typedef struct packed {
      logic             frame_abort;
      logic             sample_trigger;
      logic             code_accepted;
      logic [CodeW-1:0] code;
      logic             code_valid;
   } result_type;

   // strict window: nominal - tol < width < nominal + tol, without going negative
   function automatic logic width_match(input logic [TimeW-1:0] width,
                                        input logic [TimeW-1:0] nominal,
                                        input logic [TolW-1:0]  tol);
      logic [TimeW:0] width_tol;
      logic [TimeW:0] nom_tol;
      width_tol = {1'b0, width} + {2'b00, tol};
      nom_tol   = {1'b0, nominal} + {2'b00, tol};
      return (width_tol > {1'b0, nominal}) && ({1'b0, width} < nom_tol);
   endfunction

endpackage
`default_nettype wire

FILE: src/ipwd_classify.sv
// ipwd_classify: high time with one timer wrap correction, and the four width windows.
// Depends on ipwd_pkg.
`default_nettype none
module ipwd_classify (
   input  wire ipwd_pkg::cfg_type            cfg,
   input  wire logic [ipwd_pkg::TimeW-1:0]   rise_time,
   input  wire logic [ipwd_pkg::TimeW-1:0]   capture_time,
   output ipwd_pkg::class_type               width_class
);
   import ipwd_pkg::*;

   logic [TimeW-1:0] width;

   always_comb begin
      if (capture_time < rise_time) begin
         width = cfg.timer_period - rise_time + capture_time;
      end else begin
         width = capture_time - rise_time;
      end
   end

   assign width_class.zero_hit   = width_match(width, cfg.zero_width, cfg.tolerance);
   assign width_class.one_hit    = width_match(width, cfg.one_width, cfg.tolerance);
   assign width_class.leader_hit = width_match(width, cfg.leader_width, cfg.tolerance);
   assign width_class.end_hit    = width_match(width, cfg.end_width, cfg.tolerance);

endmodule
`default_nettype wire

FILE: src/ipwd_frame.sv
// ipwd_frame: edge and frame state, bit shifting and the result register.
// Depends on ipwd_pkg and ipwd_classify.
`default_nettype none
module ipwd_frame (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ipwd_pkg::cfg_type            cfg,
   input  wire logic                         in_valid,
   input  wire logic                         in_rising,
   input  wire logic [ipwd_pkg::TimeW-1:0]   in_capture,
   output logic                              in_ready,
   output logic                              out_valid,
   output ipwd_pkg::result_type              out_result,
   input  wire logic                         out_ready
);
   import ipwd_pkg::*;

   logic             high_started_ff, high_started_in;
   logic [TimeW-1:0] rise_time_ff, rise_time_in;
   logic             in_frame_ff, in_frame_in;
   logic [CodeW-1:0] shift_bits_ff, shift_bits_in;
   logic [1:0]       bit_count_ff, bit_count_in;
   logic             out_valid_ff, out_valid_in;
   result_type       result_ff, result_in;
   class_type        width_class;
   logic             fire;
   logic             take_bit;
   logic             bit_val;

   ipwd_classify u_classify (
      .cfg          (cfg),
      .rise_time    (rise_time_ff),
      .capture_time (in_capture),
      .width_class  (width_class)
   );

   assign in_ready = !out_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      high_started_in = high_started_ff;
      rise_time_in    = rise_time_ff;
      in_frame_in     = in_frame_ff;
      shift_bits_in   = shift_bits_ff;
      bit_count_in    = bit_count_ff;
      result_in       = result_ff;
      take_bit        = 1'b0;
      bit_val         = 1'b0;
      if (fire) begin
         result_in = '0;
         if (in_rising) begin
            rise_time_in    = in_capture;
            high_started_in = 1'b1;
         end else begin
            high_started_in = 1'b0;
            if (high_started_ff) begin
               if (in_frame_ff) begin
                  if (width_class.zero_hit) begin
                     take_bit = 1'b1;
                  end else if (width_class.one_hit) begin
                     take_bit = 1'b1;
                     bit_val  = 1'b1;
                  end else if (width_class.end_hit) begin
                     result_in.code_valid    = 1'b1;
                     result_in.code          = shift_bits_ff;
                     result_in.code_accepted = (shift_bits_ff <= AcceptMax);
                     in_frame_in             = 1'b0;
                     bit_count_in            = '0;
                  end else begin
                     result_in.frame_abort = 1'b1;
                     in_frame_in           = 1'b0;
                     bit_count_in          = '0;
                  end
               end else if (width_class.leader_hit) begin
                  in_frame_in   = 1'b1;
                  shift_bits_in = '0;
                  bit_count_in  = '0;
               end
            end
         end
         if (take_bit) begin
            shift_bits_in = {shift_bits_ff[CodeW-2:0], bit_val};
            if (bit_count_ff != CountMax) begin
               bit_count_in             = bit_count_ff + 2'd1;
               result_in.sample_trigger = (bit_count_in == CountTrig);
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_started_ff <= 1'b0;
         rise_time_ff    <= '0;
         in_frame_ff     <= 1'b0;
         shift_bits_ff   <= '0;
         bit_count_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         high_started_ff <= high_started_in;
         rise_time_ff    <= rise_time_in;
         in_frame_ff     <= in_frame_in;
         shift_bits_ff   <= shift_bits_in;
         bit_count_ff    <= bit_count_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   a_accept_needs_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.code_accepted |-> result_ff.code_valid)
      else $error("accepted code without a delivered frame");

   a_code_zero_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !result_ff.code_valid |-> result_ff.code == '0)
      else $error("code nonzero on a beat without a delivered frame");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({result_ff.code_valid, result_ff.sample_trigger,
                                 result_ff.frame_abort}))
      else $error("more than one event flag on one beat");

   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      fire && (result_in.code_valid || result_in.frame_abort) |=> !in_frame_ff
                                                                && bit_count_ff == '0)
      else $error("frame state kept after end or abort");

endmodule
`default_nettype wire

FILE: src/ir_pulse_width_decoder.sv
// A beat accepted on req_ passes the input register, then classify and frame update into
// the result register, which drives rsp_. One edge beat per cycle while rsp_tready is high;
// rsp_tready low with a result pending stalls the result register and the input register.
// Reset (synchronous, active high): frame state cleared, registers back to defaults,
// no result pending. One result beat for every input beat.
// Top level: configuration registers and input register. Depends on ipwd_pkg, ipwd_frame.
`default_nettype none
module ir_pulse_width_decoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [0] rising_edge, [16:1] capture_time, [23:17] zero
   input  wire logic [ipwd_pkg::ReqDataW-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] code_valid, [8:1] code, [9] code_accepted, [10] sample_trigger,
   // [11] frame_abort, [15:12] zero
   output logic [ipwd_pkg::RspDataW-1:0]         rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [ipwd_pkg::CsrAddrW-1:0]    csr_addr,
   input  wire logic [ipwd_pkg::CsrDataW-1:0]    csr_wdata
);
   import ipwd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             req_valid_ff, req_valid_in;
   logic             req_rising_ff, req_rising_in;
   logic [TimeW-1:0] req_capture_ff, req_capture_in;
   logic             proc_ready;
   result_type       result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_TIMER_PERIOD: cfg_in.timer_period = csr_wdata;
            REG_ZERO_WIDTH:   cfg_in.zero_width   = csr_wdata;
            REG_ONE_WIDTH:    cfg_in.one_width    = csr_wdata;
            REG_LEADER_WIDTH: cfg_in.leader_width = csr_wdata;
            REG_END_WIDTH:    cfg_in.end_width    = csr_wdata;
            REG_TOLERANCE:    cfg_in.tolerance    = csr_wdata[TolW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_period <= PeriodReset;
         cfg_ff.zero_width   <= ZeroReset;
         cfg_ff.one_width    <= OneReset;
         cfg_ff.leader_width <= LeaderReset;
         cfg_ff.end_width    <= EndReset;
         cfg_ff.tolerance    <= TolReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !req_valid_ff || proc_ready;

   always_comb begin
      req_valid_in   = req_valid_ff;
      req_rising_in  = req_rising_ff;
      req_capture_in = req_capture_ff;
      if (req_tready) begin
         req_valid_in   = req_tvalid;
         req_rising_in  = req_tdata[0];
         req_capture_in = req_tdata[TimeW:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_rising_ff  <= req_rising_in;
      req_capture_ff <= req_capture_in;
   end

   ipwd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid_ff),
      .in_rising  (req_rising_ff),
      .in_capture (req_capture_ff),
      .in_ready   (proc_ready),
      .out_valid  (rsp_tvalid),
      .out_result (result),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {{(RspDataW - $bits(result_type)){1'b0}}, result};

endmodule
`default_nettype wire
